### hw/rtl/b64sc_pkg.sv
// Shared types, codes and alphabet functions for the Base64 stream codec.
package b64sc_pkg;

  localparam logic [1:0] ErrOk      = 2'd0;
  localparam logic [1:0] ErrBadChar = 2'd1;
  localparam logic [1:0] ErrBadPad  = 2'd2;
  localparam logic [1:0] ErrBadLen  = 2'd3;

  localparam logic [7:0] PadChar       = 8'h3d;
  localparam logic [6:0] PadValue      = 7'd64;
  localparam logic [6:0] NotInAlphabet = 7'd65;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned CountW     = $clog2(MaxResults + 1);

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       msg_end;
    logic [1:0] error_code;
  } res_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] s);
    logic [7:0] c;
    if (s < 6'd26) begin
      c = 8'h41 + {2'b00, s};
    end else if (s < 6'd52) begin
      c = 8'h61 + {2'b00, s - 6'd26};
    end else if (s < 6'd62) begin
      c = 8'h30 + {2'b00, s - 6'd52};
    end else if (s == 6'd62) begin
      c = 8'h2b;
    end else begin
      c = 8'h2f;
    end
    return c;
  endfunction

  function automatic logic [6:0] char_sextet(input logic [7:0] c);
    logic [6:0] v;
    if (c >= 8'h41 && c <= 8'h5a) begin
      v = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      v = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2b) begin
      v = 7'd62;
    end else if (c == 8'h2f) begin
      v = 7'd63;
    end else if (c == PadChar) begin
      v = PadValue;
    end else begin
      v = NotInAlphabet;
    end
    return v;
  endfunction

endpackage

### hw/rtl/base64_stream_codec_unit.sv
// Base64 stream codec: encoder and decoder with a shared group register.
//
// Channel | Dir | tdata             | tlast    | tuser
// s_axis  | in  | [7:0] data_byte   | msg_last | -
// m_axis  | out | [7:0] out_byte    | msg_end  | [0] run_last, [2:1] error_code
// cfg     | in  | [0] direction     | -        | -
//
// An input word is taken into the input register in any cycle that register is free, and
// is processed combinationally and registered into the result buffer once that buffer is
// empty or drains its last result. Results leave one per cycle while the output is ready.
// Reset clears the direction (encode), the group state and both buffers.
// A stalled output holds its result; one further input word waits in the input register.
module base64_stream_codec_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,      // [0] direction
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tlast_i,   // msg_last
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o,   // msg_end
  output logic [2:0] m_axis_tuser_o    // [0] run_last, [2:1] error_code
);
  import b64sc_pkg::*;

  logic              dir_q;
  logic [1:0]        cnt_q, cnt_d;
  logic [23:0]       hold_q, hold_d;
  logic              disc_q, disc_d;

  logic              in_valid_q;
  logic [7:0]        in_data_q;
  logic              in_last_q;

  res_t              buf_q [MaxResults];
  logic [CountW-1:0] rcnt_q;

  res_t              res [MaxResults];
  logic [CountW-1:0] n_res;

  logic              pop, can_load, load, in_take;

  assign pop      = (rcnt_q != '0) && m_axis_tready_i;
  assign can_load = (rcnt_q == '0) || (rcnt_q == CountW'(1) && m_axis_tready_i);
  assign load     = in_valid_q && can_load;
  assign in_take  = s_axis_tvalid_i && s_axis_tready_o;

  assign s_axis_tready_o = !in_valid_q || load;

  // Group logic: one held word against the stored group state.
  always_comb begin
    logic [23:0] enc_hold, bits;
    logic [2:0]  enc_n;
    logic [6:0]  v;
    logic        is_pad, pad2n;
    logic [5:0]  v6;
    logic [17:0] payload_n;
    logic [23:0] all;
    logic [1:0]  npad;
    logic        fail;
    logic [1:0]  fcode;

    cnt_d  = cnt_q;
    hold_d = hold_q;
    disc_d = disc_q;
    n_res  = '0;
    for (int k = 0; k < MaxResults; k++) begin
      res[k] = '0;
    end
    enc_hold  = {hold_q[15:0], in_data_q};
    enc_n     = {1'b0, cnt_q} + 3'd1;
    bits      = enc_hold;
    v         = char_sextet(in_data_q);
    is_pad    = (v == PadValue);
    pad2n     = hold_q[23] | (is_pad && cnt_q == 2'd2);
    v6        = is_pad ? 6'd0 : v[5:0];
    payload_n = {hold_q[11:0], v6};
    all       = {hold_q[17:0], v6};
    npad      = {1'b0, is_pad} + {1'b0, hold_q[23]};
    fail      = 1'b0;
    fcode     = ErrOk;

    if (!dir_q) begin
      if (enc_n >= 3'd3 || in_last_q) begin
        case (enc_n)
          3'd1:    bits = {enc_hold[7:0], 16'h0};
          3'd2:    bits = {enc_hold[15:0], 8'h0};
          default: bits = enc_hold;
        endcase
        res[0].out_byte = sextet_char(bits[23:18]);
        res[1].out_byte = sextet_char(bits[17:12]);
        res[2].out_byte = (enc_n >= 3'd2) ? sextet_char(bits[11:6]) : PadChar;
        res[3].out_byte = (enc_n == 3'd3) ? sextet_char(bits[5:0]) : PadChar;
        res[3].run_last = 1'b1;
        res[3].msg_end  = in_last_q;
        n_res  = CountW'(4);
        cnt_d  = '0;
        hold_d = '0;
      end else begin
        cnt_d  = enc_n[1:0];
        hold_d = enc_hold;
      end
    end else if (disc_q) begin
      if (in_last_q) begin
        disc_d = 1'b0;
        cnt_d  = '0;
        hold_d = '0;
      end
    end else if (v == NotInAlphabet) begin
      fail  = 1'b1;
      fcode = ErrBadChar;
    end else if (is_pad && cnt_q < 2'd2) begin
      fail  = 1'b1;
      fcode = ErrBadPad;
    end else if (!is_pad && cnt_q == 2'd3 && hold_q[23]) begin
      fail  = 1'b1;
      fcode = ErrBadPad;
    end else if (cnt_q != 2'd3) begin
      if (in_last_q) begin
        fail  = 1'b1;
        fcode = ErrBadLen;
      end else begin
        cnt_d  = cnt_q + 2'd1;
        hold_d = {pad2n, 5'b0, payload_n};
      end
    end else if (npad != 2'd0 && !in_last_q) begin
      // A padded group must close the message.
      fail  = 1'b1;
      fcode = ErrBadPad;
    end else begin
      res[0].out_byte = all[23:16];
      res[1].out_byte = all[15:8];
      res[2].out_byte = all[7:0];
      case (npad)
        2'd0: begin
          res[2].run_last = 1'b1;
          res[2].msg_end  = in_last_q;
          n_res = CountW'(3);
        end
        2'd1: begin
          res[1].run_last = 1'b1;
          res[1].msg_end  = in_last_q;
          n_res = CountW'(2);
        end
        default: begin
          res[0].run_last = 1'b1;
          res[0].msg_end  = in_last_q;
          n_res = CountW'(1);
        end
      endcase
      cnt_d  = '0;
      hold_d = '0;
    end

    if (fail) begin
      for (int k = 0; k < MaxResults; k++) begin
        res[k] = '0;
      end
      res[0].run_last   = 1'b1;
      res[0].msg_end    = 1'b1;
      res[0].error_code = fcode;
      n_res  = CountW'(1);
      cnt_d  = '0;
      hold_d = '0;
      disc_d = !in_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q      <= 1'b0;
      cnt_q      <= '0;
      hold_q     <= '0;
      disc_q     <= 1'b0;
      in_valid_q <= 1'b0;
      rcnt_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        dir_q  <= cfg_wdata_i;
        cnt_q  <= '0;
        hold_q <= '0;
        disc_q <= 1'b0;
      end else if (load) begin
        cnt_q  <= cnt_d;
        hold_q <= hold_d;
        disc_q <= disc_d;
      end
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (load) begin
        in_valid_q <= 1'b0;
      end
      if (load) begin
        rcnt_q <= n_res;
      end else if (pop) begin
        rcnt_q <= rcnt_q - CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (load) begin
      for (int k = 0; k < MaxResults; k++) begin
        buf_q[k] <= res[k];
      end
    end else if (pop) begin
      for (int k = 0; k < MaxResults - 1; k++) begin
        buf_q[k] <= buf_q[k+1];
      end
    end
  end

  assign m_axis_tvalid_o = (rcnt_q != '0);
  assign m_axis_tdata_o  = buf_q[0].out_byte;
  assign m_axis_tlast_o  = buf_q[0].msg_end;
  assign m_axis_tuser_o  = {buf_q[0].error_code, buf_q[0].run_last};

`ifndef ASSERT_OFF
  // The result buffer never holds more than one word's results.
  a_rcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rcnt_q <= CountW'(MaxResults))
    else $error("result count out of range");

  // An error result always closes both the word's run and the message.
  a_err_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[2:1] != ErrOk |-> m_axis_tlast_o && m_axis_tuser_o[0])
    else $error("error result without run and message end");

  // The encoder never reports an error.
  a_enc_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !dir_q |-> m_axis_tuser_o[2:1] == ErrOk)
    else $error("error code in encode mode");

  // Only the final result of a run may be taken as the run's end.
  a_run_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> rcnt_q == CountW'(1))
    else $error("run end before the last buffered result");
`endif

endmodule

### tb/base64_stream_codec_unit_tb.sv
// Testbench for the Base64 stream codec: directed and random messages in both directions.
`timescale 1ns / 100ps

module base64_stream_codec_unit_tb;
  import b64sc_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       s_valid = 1'b0;
  logic [7:0] s_data = 8'h00;
  logic       s_last = 1'b0;
  logic       m_ready = 1'b0;
  logic       s_ready;
  logic       m_valid;
  logic [7:0] m_data;
  logic       m_last;
  logic [2:0] m_user;

  string b64_alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  word_t tx_word_q[$];
  res_t  awaited_res_q[$];
  int    words_pushed = 0;
  int    words_accepted = 0;
  int    mismatches = 0;
  int    idle_lvl = 1;
  int    tx_gap = 0;
  int    rx_gap = 0;
  bit    in_taken = 1'b0;
  bit    rx_block = 1'b0;

  // Mirror of the codec state.
  logic        pred_dir = 1'b0;
  logic [1:0]  pred_cnt = 2'd0;
  logic [23:0] pred_hold = 24'd0;
  logic        pred_drop = 1'b0;

  base64_stream_codec_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .m_axis_tuser_o  (m_user)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    int i;
    if (c == PadChar) return PadValue;
    for (i = 0; i < 64; i++) begin
      if (b64_alpha[i] == c) return 7'(i);
    end
    return NotInAlphabet;
  endfunction

  // Back-to-back at level 0; otherwise mostly back-to-back or a short gap, rarely a long one.
  function automatic int pick_gap(input int lvl);
    int r;
    if (lvl == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 100 - 30 * lvl) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic push_res(input logic [7:0] b, input logic rl, input logic me,
                          input logic [1:0] ec);
    res_t r;
    r.out_byte   = b;
    r.run_last   = rl;
    r.msg_end    = me;
    r.error_code = ec;
    awaited_res_q.push_back(r);
  endtask

  task automatic clear_group();
    pred_cnt  = 2'd0;
    pred_hold = 24'd0;
  endtask

  task automatic dec_fail(input logic [1:0] ec, input logic last);
    push_res(8'h00, 1'b1, 1'b1, ec);
    clear_group();
    pred_drop = !last;
  endtask

  task automatic codec_predict(input logic [7:0] d, input logic last);
    logic [23:0] bits;
    logic [23:0] all;
    logic [17:0] payload;
    logic [6:0]  v;
    logic [5:0]  v6;
    logic [1:0]  pos;
    logic        pad2;
    int          n;
    int          npad;
    int          nbytes;
    int          k;
    if (!pred_dir) begin
      pred_hold = {pred_hold[15:0], d};
      pred_cnt  = pred_cnt + 2'd1;
      if (pred_cnt == 2'd3 || last) begin
        n    = pred_cnt;
        bits = pred_hold << (8 * (3 - n));
        push_res(b64_alpha[bits[23:18]], 1'b0, 1'b0, ErrOk);
        push_res(b64_alpha[bits[17:12]], 1'b0, 1'b0, ErrOk);
        push_res(n >= 2 ? b64_alpha[bits[11:6]] : PadChar, 1'b0, 1'b0, ErrOk);
        push_res(n == 3 ? b64_alpha[bits[5:0]] : PadChar, 1'b1, last, ErrOk);
        clear_group();
      end
    end else if (pred_drop) begin
      if (last) begin
        pred_drop = 1'b0;
        clear_group();
      end
    end else begin
      v       = sextet_of(d);
      pos     = pred_cnt;
      pad2    = pred_hold[23];
      payload = pred_hold[17:0];
      if (v == NotInAlphabet) begin
        dec_fail(ErrBadChar, last);
      end else if (v == PadValue && pos < 2'd2) begin
        dec_fail(ErrBadPad, last);
      end else if (v != PadValue && pos == 2'd3 && pad2) begin
        dec_fail(ErrBadPad, last);
      end else begin
        if (v == PadValue && pos == 2'd2) pad2 = 1'b1;
        v6 = (v == PadValue) ? 6'd0 : v[5:0];
        if (pos < 2'd3) begin
          payload   = {payload[11:0], v6};
          pred_hold = {pad2, 5'd0, payload};
          pred_cnt  = pos + 2'd1;
          if (last) dec_fail(ErrBadLen, last);
        end else begin
          all    = {payload, v6};
          npad   = int'(v == PadValue) + int'(pad2);
          nbytes = 3 - npad;
          // A padded group is only legal as the final group of the message.
          if (npad > 0 && !last) begin
            dec_fail(ErrBadPad, last);
          end else begin
            for (k = 0; k < nbytes; k++) begin
              push_res(all[23 - 8 * k -: 8], k + 1 == nbytes,
                       (k + 1 == nbytes) && last, ErrOk);
            end
            clear_group();
          end
        end
      end
    end
  endtask

  task automatic send(input logic [7:0] d, input logic last);
    word_t w;
    w.data = d;
    w.last = last;
    tx_word_q.push_back(w);
    words_pushed++;
  endtask

  task automatic send_text(input string s, input logic last_at_end);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send(s[i], last_at_end && i == s.len() - 1);
    end
  endtask

  task automatic rand_enc_msg();
    int n;
    int i;
    n = $urandom_range(1, 10);
    for (i = 0; i < n; i++) begin
      send(8'($urandom_range(0, 255)), i == n - 1);
    end
  endtask

  // Well-formed message with random content; about one in five gets a random byte, a pad or a cut.
  task automatic rand_dec_msg();
    logic [7:0] m[$];
    int         ng;
    int         npad;
    int         j;
    int         k;
    ng = $urandom_range(1, 3);
    for (k = 0; k < ng * 4; k++) begin
      m.push_back(b64_alpha[$urandom_range(0, 63)]);
    end
    npad = $urandom_range(0, 2);
    for (k = 0; k < npad; k++) begin
      m[m.size() - 1 - k] = PadChar;
    end
    if ($urandom_range(0, 99) >= 80) begin
      j = $urandom_range(0, m.size() - 1);
      case ($urandom_range(0, 2))
        0: begin
          m[j] = 8'($urandom_range(0, 255));
        end
        1: begin
          m[j] = PadChar;
        end
        default: begin
          m = m[0:j];
        end
      endcase
    end
    for (k = 0; k < m.size(); k++) begin
      send(m[k], k == m.size() - 1);
    end
  endtask

  // The sender holds back here until every result has come out, then lets the tail drain.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (words_accepted != words_pushed || awaited_res_q.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_direction(input logic d);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    pred_dir  = d;
    pred_drop = 1'b0;
    clear_group();
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  always @(negedge clk_i) begin : drive_words
    word_t w;
    if (rst_ni && (!s_valid || in_taken)) begin
      in_taken = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
        s_valid <= 1'b0;
      end else if (tx_word_q.size() > 0) begin
        w = tx_word_q.pop_front();
        s_valid <= 1'b1;
        s_data  <= w.data;
        s_last  <= w.last;
        tx_gap  = pick_gap(idle_lvl);
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rx_block) begin
      m_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
      rx_gap = pick_gap(idle_lvl);
    end
  end

  // One long receiver stall while the sender still has words queued up to offer.
  initial begin
    do @(negedge clk_i);
    while (words_accepted < 80 || tx_word_q.size() < 2);
    rx_block = 1'b1;
    repeat (100) @(negedge clk_i);
    rx_block = 1'b0;
  end

  always @(posedge clk_i) begin : check_words
    res_t got;
    res_t want;
    if (rst_ni) begin
      if (s_valid && s_ready) begin
        codec_predict(s_data, s_last);
        words_accepted++;
        in_taken = 1'b1;
      end
      if (m_valid && m_ready) begin
        got.out_byte   = m_data;
        got.run_last   = m_user[0];
        got.msg_end    = m_last;
        got.error_code = m_user[2:1];
        if (awaited_res_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word, expected none,", $time,
                   " got byte %h run_last %b msg_end %b err %0d",
                   got.out_byte, got.run_last, got.msg_end, got.error_code);
        end else begin
          want = awaited_res_q.pop_front();
          if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
              got.msg_end !== want.msg_end || got.error_code !== want.error_code) begin
            mismatches++;
            $display("%0t: expected byte %h run_last %b msg_end %b err %0d,", $time,
                     want.out_byte, want.run_last, want.msg_end, want.error_code,
                     " got byte %h run_last %b msg_end %b err %0d",
                     got.out_byte, got.run_last, got.msg_end, got.error_code);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int phase;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    idle_lvl = 1;
    @(posedge clk_i);

    // Encoding: one and two byte tails, a full group followed by a short one.
    send(8'h00, 1'b1);
    send(8'hff, 1'b0);
    send(8'h00, 1'b1);
    send(8'hff, 1'b0);
    send(8'hff, 1'b0);
    send(8'ha5, 1'b0);
    send(8'h7f, 1'b1);
    wait_idle();

    set_direction(1'b1);
    @(posedge clk_i);
    // Alphabet ends, double pad with nonzero pad bits, bad character with discard,
    // non-pad after pad, pad in a middle group, bad length, and early pad.
    send_text("+/09", 1'b0);
    send_text("TR==", 1'b1);
    send_text("A#Z", 1'b1);
    send_text("AB=C", 1'b1);
    send_text("QR==", 1'b0);
    send_text("Z", 1'b1);
    send_text("Zm", 1'b1);
    send_text("A=", 1'b1);

    phase = 0;
    while (words_pushed < 180) begin
      wait_idle();
      set_direction(phase == 0 ? 1'b0 : 1'($urandom_range(0, 1)));
      idle_lvl = $urandom_range(0, 2);
      @(posedge clk_i);
      repeat ($urandom_range(4, 8)) begin
        if (pred_dir) rand_dec_msg();
        else rand_enc_msg();
      end
      phase++;
    end
    wait_idle();

    if (mismatches == 0 && awaited_res_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

### files.f
hw/rtl/b64sc_pkg.sv
hw/rtl/base64_stream_codec_unit.sv
tb/base64_stream_codec_unit_tb.sv
